// ----- rtl/gcl_pkg.sv -----
package gcl_pkg;

    // Operand width used by the arithmetic (4..32); port widths stay fixed.
    localparam int OW    = 32;
    localparam int AW    = OW + 1;
    localparam int CW    = $clog2(OW + 1);
    localparam int IN_W  = 32;
    localparam int ANS_W = 64;

    typedef enum logic [0:0] {
        CMD_GCD = 1'b0,
        CMD_LCM = 1'b1
    } gcl_cmd_t;

    typedef enum logic [0:0] {
        ALU_SUB,
        ALU_ADD
    } gcl_alu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_SHIFT,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } gcl_state_t;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_GCD,
        DP_SHIFT,
        DP_DIV_INIT,
        DP_DIV,
        DP_MUL
    } gcl_dp_op_t;

    typedef struct packed {
        gcl_dp_op_t dp_op;
        logic       idle;
        logic       out_load;
    } gcl_ctrl_t;

    typedef struct packed {
        logic     in_zero;
        logic     diff_zero;
        logic     both_even;
        gcl_cmd_t cmd;
    } gcl_status_t;

endpackage

// ----- rtl/gcd_lcm_unit.sv -----
// Greatest common divisor / least common multiple unit.
// Input channel: in_valid/in_stall with command, first_value, second_value.
//   A beat is taken when in_valid is high and in_stall is low. in_stall is
//   low only while the unit is idle; it rises the cycle after a beat is taken.
// Output channel: out_valid/out_stall with answer and bad_operand, one result
//   beat per input beat, held in an output register until taken.
// Command 0 answers the GCD; command 1 answers the full-width LCM. A zero
// operand answers 0 with bad_operand set, without running the loop.
// One shared add/subtract unit does all the work. The binary GCD loop runs
// first, then shifts to restore the common factors of two; LCM then adds
// OW divide steps and OW shift-add multiply steps (OW = 32).
// A new item is taken only after the previous one has left the loop; it may
// run while the prior result still waits in the output register.
// Reset clears the sequencer and the output valid; no result is pending.
// A stalled output holds its beat; a finished result then waits in the
// sequencer until the output register frees up.
module gcd_lcm_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [gcl_pkg::IN_W-1:0]      first_value,
    input  logic [gcl_pkg::IN_W-1:0]      second_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gcl_pkg::ANS_W-1:0]     answer,
    output logic                          bad_operand
);
    import gcl_pkg::*;

    gcl_ctrl_t        ctrl;
    gcl_status_t      sts;
    logic [ANS_W-1:0] result;
    logic             result_bad;
    logic             out_free;

    logic             out_valid_reg, out_valid_next;
    logic [ANS_W-1:0] answer_reg, answer_next;
    logic             bad_reg, bad_next;

    // Output register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    gcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .sts      (sts),
        .ctrl     (ctrl)
    );

    gcl_dpath u_dpath (
        .clk          (clk),
        .ctrl         (ctrl),
        .command      (command),
        .first_value  (first_value),
        .second_value (second_value),
        .sts          (sts),
        .result       (result),
        .result_bad   (result_bad)
    );

    assign in_stall = !ctrl.idle;

    // Output stage: load a finished result, drop valid once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        answer_next    = answer_reg;
        bad_next       = bad_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
            answer_next    = result;
            bad_next       = result_bad;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        answer_reg <= answer_next;
        bad_reg    <= bad_next;
    end

    assign out_valid   = out_valid_reg;
    assign answer      = answer_reg;
    assign bad_operand = bad_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_operand) |-> (answer == '0))
        else $error("bad operand result with nonzero answer");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a previous item still runs");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> out_valid)
        else $error("finished result not presented");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> out_free)
        else $error("result loaded over a pending beat");

endmodule

// ----- rtl/gcl_alu.sv -----
module gcl_alu (
    input  gcl_pkg::gcl_alu_op_t        op,
    input  logic [gcl_pkg::AW-1:0]      op_a,
    input  logic [gcl_pkg::AW-1:0]      op_b,
    output logic [gcl_pkg::AW-1:0]      result,
    output logic                        borrow
);
    import gcl_pkg::*;

    logic [AW:0] wide;

    always_comb
    begin
        if (op == ALU_ADD)
        begin
            wide = {1'b0, op_a} + {1'b0, op_b};
        end
        else
        begin
            wide = {1'b0, op_a} - {1'b0, op_b};
        end
        result = wide[AW-1:0];
        borrow = wide[AW];
    end

endmodule

// ----- rtl/gcl_dpath.sv -----
module gcl_dpath (
    input  logic                         clk,
    input  gcl_pkg::gcl_ctrl_t           ctrl,
    input  logic                         command,
    input  logic [gcl_pkg::IN_W-1:0]     first_value,
    input  logic [gcl_pkg::IN_W-1:0]     second_value,
    output gcl_pkg::gcl_status_t         sts,
    output logic [gcl_pkg::ANS_W-1:0]    result,
    output logic                         result_bad
);
    import gcl_pkg::*;

    logic [OW-1:0] a_reg, a_next;
    logic [OW-1:0] b_reg, b_next;
    logic [OW-1:0] x_reg, x_next;
    logic [OW-1:0] y_reg, y_next;
    gcl_cmd_t      cmd_reg, cmd_next;
    logic          bad_reg, bad_next;

    gcl_alu_op_t   alu_op;
    logic [AW-1:0] alu_a;
    logic [AW-1:0] alu_b;
    logic [AW-1:0] alu_res;
    logic          alu_borrow;
    logic [OW-1:0] in_a;
    logic [OW-1:0] in_b;

    assign in_a = first_value[OW-1:0];
    assign in_b = second_value[OW-1:0];

    // Operand steering into the shared add/subtract unit.
    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, a_reg};
        alu_b  = {1'b0, b_reg};
        case (ctrl.dp_op)
            DP_DIV:
            begin
                alu_a = {a_reg, x_reg[OW-1]};
            end
            DP_MUL:
            begin
                alu_op = ALU_ADD;
                alu_b  = x_reg[0] ? {1'b0, y_reg} : '0;
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    gcl_alu u_alu (
        .op     (alu_op),
        .op_a   (alu_a),
        .op_b   (alu_b),
        .result (alu_res),
        .borrow (alu_borrow)
    );

    assign sts.in_zero   = (in_a == '0) || (in_b == '0);
    assign sts.diff_zero = (alu_res == '0);
    assign sts.both_even = !a_reg[0] && !b_reg[0];
    assign sts.cmd       = cmd_reg;

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        cmd_next = cmd_reg;
        bad_next = bad_reg;
        case (ctrl.dp_op)
            DP_LOAD:
            begin
                a_next   = in_a;
                b_next   = in_b;
                x_next   = in_a;
                y_next   = in_b;
                cmd_next = gcl_cmd_t'(command);
                bad_next = sts.in_zero;
            end
            DP_GCD:
            begin
                // binary GCD: strip factors of two, else with both odd swap if a < b, else subtract and halve
                if (alu_res != '0)
                begin
                    if (!a_reg[0])
                    begin
                        a_next = {1'b0, a_reg[OW-1:1]};
                        if (!b_reg[0])
                        begin
                            b_next = {1'b0, b_reg[OW-1:1]};
                        end
                    end
                    else if (!b_reg[0])
                    begin
                        b_next = {1'b0, b_reg[OW-1:1]};
                    end
                    else if (alu_borrow)
                    begin
                        a_next = b_reg;
                        b_next = a_reg;
                    end
                    else
                    begin
                        a_next = {1'b0, alu_res[OW-1:1]};
                    end
                end
            end
            DP_SHIFT:
            begin
                a_next = {a_reg[OW-2:0], 1'b0};
            end
            DP_DIV_INIT:
            begin
                b_next = a_reg;
                a_next = '0;
            end
            DP_DIV:
            begin
                if (alu_borrow)
                begin
                    a_next = {a_reg[OW-2:0], x_reg[OW-1]};
                end
                else
                begin
                    a_next = alu_res[OW-1:0];
                end
                x_next = {x_reg[OW-2:0], !alu_borrow};
            end
            DP_MUL:
            begin
                a_next = alu_res[AW-1:1];
                x_next = {alu_res[0], x_reg[OW-1:1]};
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cmd_reg <= cmd_next;
        bad_reg <= bad_next;
    end

    always_comb
    begin
        if (bad_reg)
        begin
            result = '0;
        end
        else if (cmd_reg == CMD_LCM)
        begin
            result = ANS_W'({a_reg, x_reg});
        end
        else
        begin
            result = ANS_W'(b_reg);
        end
    end

    assign result_bad = bad_reg;

endmodule

// ----- rtl/gcl_ctrl.sv -----
module gcl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_free,
    input  gcl_pkg::gcl_status_t  sts,
    output gcl_pkg::gcl_ctrl_t    ctrl
);
    import gcl_pkg::*;

    gcl_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ctrl.dp_op    = DP_HOLD;
        ctrl.idle     = 1'b0;
        ctrl.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.idle = 1'b1;
                if (in_valid)
                begin
                    ctrl.dp_op = DP_LOAD;
                    cnt_next   = '0;
                    state_next = sts.in_zero ? ST_DONE : ST_GCD;
                end
            end
            ST_GCD:
            begin
                ctrl.dp_op = DP_GCD;
                if (sts.diff_zero)
                begin
                    state_next = ST_SHIFT;
                end
                else if (sts.both_even)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_SHIFT:
            begin
                // restore the common factors of two
                if (cnt_reg != '0)
                begin
                    ctrl.dp_op = DP_SHIFT;
                    cnt_next   = cnt_reg - CW'(1);
                end
                else
                begin
                    ctrl.dp_op = DP_DIV_INIT;
                    cnt_next   = CW'(OW);
                    state_next = (sts.cmd == CMD_LCM) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                ctrl.dp_op = DP_DIV;
                cnt_next   = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    cnt_next   = CW'(OW);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctrl.dp_op = DP_MUL;
                cnt_next   = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import gcl_pkg::*;

    // Operands are cut to the unit's arithmetic width before any math.
    localparam logic [63:0] OPERAND_MASK = (64'd1 << OW) - 64'd1;
    // Quiet tail after the drain, scaled with OW; give the tail some slack.
    localparam int TAIL_CYCLES = 6 * OW + 50;
    // Receiver hold-off long enough for the unit to fill and stall its input.
    localparam int LONG_HOLD_CYCLES = 1200;

    typedef struct packed {
        logic [ANS_W-1:0] answer;
        logic             bad_operand;
    } outcome_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              command;
    logic [IN_W-1:0]   first_value;
    logic [IN_W-1:0]   second_value;
    logic              out_valid;
    logic              out_stall;
    logic [ANS_W-1:0]  answer;
    logic              bad_operand;

    // Predicted outcomes, oldest first, one per accepted input beat.
    outcome_t pending_answers[$];
    int       mismatch_count;
    // Random idling on both channels; cleared for the final stretch.
    bit       idle_on;
    // Set by a test to ask the receiver for one long hold-off, in cycles.
    int       hold_request;

    gcd_lcm_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .first_value  (first_value),
        .second_value (second_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .answer       (answer),
        .bad_operand  (bad_operand)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: Euclid by remainder on the masked operands. The multiple
    // is formed as (x / g) * y, which always fits in 64 bits.
    // ------------------------------------------------------------------
    function automatic outcome_t predict_outcome(gcl_cmd_t cmd, logic [IN_W-1:0] a,
                                                 logic [IN_W-1:0] b);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] g;
        logic [63:0] r;
        logic [63:0] t;
        outcome_t    o;
        x = {32'd0, a} & OPERAND_MASK;
        y = {32'd0, b} & OPERAND_MASK;
        o.answer      = '0;
        o.bad_operand = 1'b1;
        if (x != 64'd0 && y != 64'd0)
        begin
            g = x;
            r = y;
            while (r != 64'd0)
            begin
                t = g % r;
                g = r;
                r = t;
            end
            o.bad_operand = 1'b0;
            o.answer      = (cmd == CMD_GCD) ? g : (x / g) * y;
        end
        return o;
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Send one input beat. Payload and valid change only once the previous
    // beat was taken, so a stalled beat holds steady. An optional idle
    // burst drops valid first; otherwise valid stays high back to back.
    // ------------------------------------------------------------------
    task automatic send_item(gcl_cmd_t cmd, logic [IN_W-1:0] a, logic [IN_W-1:0] b);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        first_value  <= a;
        second_value <= b;
        @(posedge clk);
        // Values read here are the ones from just before the edge.
        while (in_stall)
            @(posedge clk);
        pending_answers.push_back(predict_outcome(cmd, a, b));
    endtask

    // Mostly full-range values, with a share of small values (zero among
    // them), single-bit powers of two and the all-ones value.
    function automatic logic [IN_W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 15);
            1:       return 32'd1 << $urandom_range(0, 31);
            2:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_item();
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] f;
        gcl_cmd_t        cmd;
        cmd = gcl_cmd_t'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                // Build both operands on one shared factor so the divisor
                // is large and the loop runs through real reductions.
                f = $urandom_range(1, 65535);
                a = f * $urandom_range(1, 65535);
                b = f * $urandom_range(1, 65535);
            end
            3:
            begin
                a = random_operand();
                b = a;
            end
            default:
            begin
                a = random_operand();
                b = random_operand();
            end
        endcase
        send_item(cmd, a, b);
    endtask

    // Hold the sender until every outstanding beat has come back.
    task automatic wait_for_drain();
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, equal operands, large coprime pairs whose multiple
    // reaches the top of the 64-bit range, powers of two, and a pattern
    // pair that toggles every operand bit.
    task automatic test_extremes();
        send_item(CMD_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_GCD, 32'd1, 32'd1);
        send_item(CMD_LCM, 32'd1, 32'hFFFF_FFFF);
        send_item(CMD_LCM, 32'hFFFF_FFFF, 32'd1);
        send_item(CMD_LCM, 32'd4294967291, 32'd4294967279);
        send_item(CMD_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(CMD_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(CMD_GCD, 32'h8000_0000, 32'h4000_0000);
        send_item(CMD_LCM, 32'h8000_0000, 32'd3);
        send_item(CMD_GCD, 32'd12345, 32'd12345);
        send_item(CMD_GCD, 32'd1071, 32'd462);
        send_item(CMD_LCM, 32'd1071, 32'd462);
        send_item(CMD_GCD, 32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    // Zero on either side, or both, under each command.
    task automatic test_zero_operands();
        send_item(CMD_GCD, 32'd0, 32'd7);
        send_item(CMD_LCM, 32'd7, 32'd0);
        send_item(CMD_GCD, 32'd0, 32'd0);
        send_item(CMD_LCM, 32'd0, 32'd0);
        send_item(CMD_LCM, 32'd0, 32'hFFFF_FFFF);
        send_item(CMD_GCD, 32'hFFFF_FFFF, 32'd0);
    endtask

    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++)
            send_random_item();
    endtask

    // Stop taking results for a long stretch while beats keep coming, so
    // the output register and the sequencer fill and the input stalls.
    task automatic test_output_hold();
        idle_on      = 1'b0;
        hold_request = LONG_HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_random_item();
        in_valid <= 1'b0;
        wait_for_drain();
        idle_on = 1'b1;
    endtask

    // Short groups, each followed by a full pause until the unit is empty.
    task automatic test_drain_pause();
        for (int grp = 0; grp < 5; grp++)
        begin
            for (int i = 0; i < 20; i++)
                send_random_item();
            in_valid <= 1'b0;
            wait_for_drain();
        end
    endtask

    // Final stretch: no idling anywhere, beats back to back.
    task automatic test_streaming(int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_random_item();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus the long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin : output_stall_gen
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                burst        = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
                flag_mismatch($sformatf("result beat with nothing outstanding, answer %0h",
                                        answer));
            else
            begin
                want = pending_answers.pop_front();
                if (answer !== want.answer)
                    flag_mismatch($sformatf("answer %0h, predicted %0h",
                                            answer, want.answer));
                if (bad_operand !== want.bad_operand)
                    flag_mismatch($sformatf("bad_operand %0b, predicted %0b",
                                            bad_operand, want.bad_operand));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_GCD;
        first_value    = '0;
        second_value   = '0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        hold_request   = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_zero_operands();
        test_random_mix(800);
        test_output_hold();
        test_drain_pause();
        test_streaming(450);

        // Drop valid in the step of the last acceptance, then let the
        // unit drain and sit quiet long enough to expose a stray beat.
        in_valid <= 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending_answers.size());
        $display("simulation failed");
        $finish;
    end

endmodule
